/* rtl/rwst_pkg.sv */
// ----------------------------------------------------------------------------
// rwst_pkg
// Types, constants and the hash mixing function used by the write-stamp
// table controller and datapath.
// ----------------------------------------------------------------------------
package rwst_pkg;

   typedef enum logic [2:0] {
      ACT_WRITE  = 3'd0,
      ACT_READ   = 3'd1,
      ACT_INVAL  = 3'd2,
      ACT_COMMIT = 3'd3,
      ACT_END    = 3'd4,
      ACT_QUERY  = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_CMT_RD,
      ST_CMT_LOAD,
      ST_HASH,
      ST_MOD,
      ST_SLOT_RD,
      ST_SLOT_USE,
      ST_DONE
   } state_type;

   localparam logic [31:0] HASH_SEED = 32'h9E73_5654;
   localparam logic [4:0]  HASH_LAST = 5'd6;
   localparam logic [4:0]  MOD_LAST  = 5'd2;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } hash_type;

   typedef struct packed {
      logic load_item;
      logic clr_wr;
      logic res_invalid;
      logic res_wrote;
      logic res_read;
      logic epoch_inc;
      logic ws_clear;
      logic idx_clear;
      logic idx_inc;
      logic ws_append;
      logic last_set;
      logic hash_init;
      logic hash_init_ws;
      logic hash_step;
      logic mod_step;
      logic slot_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       track;
      logic       id_zero;
      logic       id_is_last;
      logic       overflow;
      logic       idx_end;
      logic       ws_match;
      logic       hash_done;
      logic       mod_done;
      logic       clr_done;
      logic       rsp_free;
   } status_type;

   function automatic logic [31:0] rotl(logic [31:0] x, int k);
      return (x << k) | (x >> (32 - k));
   endfunction

   function automatic hash_type hash_mix(hash_type h, logic [2:0] step);
      hash_type r;
      r = h;
      case (step)
         3'd0: begin r.c = (h.c ^ h.b) - rotl(h.b, 14); end
         3'd1: begin r.a = (h.a ^ h.c) - rotl(h.c, 11); end
         3'd2: begin r.b = (h.b ^ h.a) - rotl(h.a, 25); end
         3'd3: begin r.c = (h.c ^ h.b) - rotl(h.b, 16); end
         3'd4: begin r.a = (h.a ^ h.c) - rotl(h.c, 4); end
         3'd5: begin r.b = (h.b ^ h.a) - rotl(h.a, 14); end
         3'd6: begin r.c = (h.c ^ h.b) - rotl(h.b, 24); end
         default: begin r = h; end
      endcase
      return r;
   endfunction

endpackage

/* rtl/rwst_ram.sv */
// ----------------------------------------------------------------------------
// rwst_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rwst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rwst_datapath.sv */
// ----------------------------------------------------------------------------
// rwst_datapath
// Slot table, write set, hash and remainder unit, counters and result
// registers of the write-stamp table.
// ----------------------------------------------------------------------------
module rwst_datapath
   import rwst_pkg::*;
#(
   parameter int SLOT_COUNT      = 8192,
   parameter int WRITE_SET_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   stat,
   input  logic [2:0]   req_tuser,
   input  logic [31:0]  req_tdata,
   input  logic         csr_valid,
   input  logic         csr_data,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic [199:0] rsp_tdata,
   output logic         rsp_tuser
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int RW     = SLOT_W + 1;
   localparam int WS_AW  = (WRITE_SET_DEPTH > 1) ? $clog2(WRITE_SET_DEPTH) : 1;
   localparam int WS_CW  = $clog2(WRITE_SET_DEPTH + 1);
   localparam int SLOT_DW = 160;
   localparam logic [31:0] SLOT_N = 32'(SLOT_COUNT);
   localparam logic [31:0] RECIP  = 32'(64'h1_0000_0000 / 64'(SLOT_COUNT));

   logic              track_ff, track_in;
   logic [2:0]        action_ff, action_in;
   logic [31:0]       id_ff, id_in;
   logic [31:0]       tgt_ff, tgt_in;
   hash_type          h_ff, h_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [31:0]       quot_ff, quot_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [63:0]       stamp_ctr_ff, stamp_ctr_in;
   logic [63:0]       epoch_ff, epoch_in;
   logic [WS_CW-1:0]  ws_cnt_ff, ws_cnt_in;
   logic [WS_CW-1:0]  idx_ff, idx_in;
   logic [31:0]       last_ff, last_in;
   logic              ovf_ff, ovf_in;
   logic [63:0]       res_stamp_ff, res_stamp_in;
   logic [63:0]       res_gen_ff, res_gen_in;
   logic [63:0]       res_epoch_ff, res_epoch_in;
   logic              res_inv_ff, res_inv_in;
   logic              res_wrote_ff, res_wrote_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [199:0]      rsp_data_ff, rsp_data_in;
   logic              rsp_inv_ff, rsp_inv_in;

   logic [SLOT_DW-1:0] slot_rd;
   logic [SLOT_DW-1:0] slot_wdata;
   logic [SLOT_W-1:0]  slot_waddr;
   logic               slot_we;
   logic [31:0]        ws_rd;
   logic               ws_we;
   logic [31:0]        owner;
   logic [63:0]        old_stamp;
   logic [63:0]        old_gen;
   logic [63:0]        new_gen;
   logic [63:0]        recip_prod;
   logic [31:0]        rem_wide;
   logic [31:0]        hash_src;
   logic               ws_room;

   assign owner      = slot_rd[31:0];
   assign old_stamp  = slot_rd[95:32];
   assign old_gen    = slot_rd[159:96];
   assign new_gen    = old_gen + {63'd0, (owner != tgt_ff) && (owner != 32'd0)};
   assign recip_prod = 64'(h_ff.c) * 64'(RECIP);
   assign rem_wide   = h_ff.c - quot_ff * SLOT_N;
   assign hash_src   = cmd.hash_init_ws ? ws_rd : id_ff;
   assign ws_room    = ws_cnt_ff < WS_CW'(WRITE_SET_DEPTH);

   assign slot_we    = cmd.clr_wr | cmd.slot_wr;
   assign slot_waddr = cmd.clr_wr ? clr_ff : rem_ff[SLOT_W-1:0];
   assign slot_wdata = cmd.clr_wr ? '0 : {new_gen, stamp_ctr_ff + 64'd1, tgt_ff};
   assign ws_we      = cmd.ws_append & ws_room;

   rwst_ram #(.WIDTH(SLOT_DW), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (rem_ff[SLOT_W-1:0]),
      .rd_data (slot_rd)
   );

   rwst_ram #(.WIDTH(32), .DEPTH(WRITE_SET_DEPTH)) u_ws_ram (
      .clock   (clock),
      .wr_en   (ws_we),
      .wr_addr (ws_cnt_ff[WS_AW-1:0]),
      .wr_data (id_ff),
      .rd_addr (idx_ff[WS_AW-1:0]),
      .rd_data (ws_rd)
   );

   always_comb begin
      track_in     = csr_valid ? csr_data : track_ff;
      action_in    = action_ff;
      id_in        = id_ff;
      tgt_in       = tgt_ff;
      h_in         = h_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      clr_in       = clr_ff;
      stamp_ctr_in = stamp_ctr_ff;
      epoch_in     = epoch_ff;
      ws_cnt_in    = ws_cnt_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      ovf_in       = ovf_ff;
      res_stamp_in = res_stamp_ff;
      res_gen_in   = res_gen_ff;
      res_epoch_in = res_epoch_ff;
      res_inv_in   = res_inv_ff;
      res_wrote_in = res_wrote_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_inv_in   = rsp_inv_ff;

      if (cmd.load_item) begin
         action_in    = req_tuser;
         id_in        = req_tdata;
         res_stamp_in = '0;
         res_gen_in   = '0;
         res_epoch_in = '0;
         res_inv_in   = 1'b0;
         res_wrote_in = 1'b0;
      end
      if (cmd.clr_wr) begin
         clr_in = clr_ff + SLOT_W'(1);
      end
      if (cmd.res_invalid) begin
         res_inv_in = 1'b1;
      end
      if (cmd.res_wrote) begin
         res_wrote_in = 1'b1;
      end
      if (cmd.res_read) begin
         res_stamp_in = (owner == tgt_ff) ? old_stamp : 64'd0;
         res_gen_in   = old_gen;
         res_epoch_in = epoch_ff;
      end
      if (cmd.epoch_inc) begin
         epoch_in = epoch_ff + 64'd1;
      end
      if (cmd.ws_clear) begin
         ws_cnt_in = '0;
         last_in   = '0;
         ovf_in    = 1'b0;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + WS_CW'(1);
      end
      if (cmd.ws_append) begin
         last_in = id_ff;
         if (ws_room) begin
            ws_cnt_in = ws_cnt_ff + WS_CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.last_set) begin
         last_in = id_ff;
      end
      if (cmd.hash_init) begin
         tgt_in = hash_src;
         h_in   = '{a: HASH_SEED + hash_src, b: HASH_SEED, c: HASH_SEED};
         cnt_in = '0;
         rem_in = '0;
      end
      if (cmd.hash_step) begin
         h_in   = hash_mix(h_ff, cnt_ff[2:0]);
         cnt_in = (cnt_ff == HASH_LAST) ? 5'd0 : cnt_ff + 5'd1;
      end
      if (cmd.mod_step) begin
         if (cnt_ff == 5'd0) begin
            quot_in = recip_prod[63:32];
         end else if (cnt_ff == 5'd1) begin
            rem_in = rem_wide[RW-1:0];
         end else begin
            rem_in = (rem_ff >= RW'(SLOT_COUNT)) ? rem_ff - RW'(SLOT_COUNT) : rem_ff;
         end
         cnt_in = cnt_ff + 5'd1;
      end
      if (cmd.slot_wr) begin
         stamp_ctr_in = stamp_ctr_ff + 64'd1;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, res_wrote_ff, res_epoch_ff, res_gen_ff, res_stamp_ff};
         rsp_inv_in   = res_inv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= 1'b0;
         clr_ff       <= '0;
         stamp_ctr_ff <= 64'd1;
         epoch_ff     <= '0;
         ws_cnt_ff    <= '0;
         last_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         track_ff     <= track_in;
         clr_ff       <= clr_in;
         stamp_ctr_ff <= stamp_ctr_in;
         epoch_ff     <= epoch_in;
         ws_cnt_ff    <= ws_cnt_in;
         last_ff      <= last_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      id_ff        <= id_in;
      tgt_ff       <= tgt_in;
      h_ff         <= h_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      idx_ff       <= idx_in;
      res_stamp_ff <= res_stamp_in;
      res_gen_ff   <= res_gen_in;
      res_epoch_ff <= res_epoch_in;
      res_inv_ff   <= res_inv_in;
      res_wrote_ff <= res_wrote_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_inv_ff   <= rsp_inv_in;
   end

   assign stat.action     = action_ff;
   assign stat.track      = track_ff;
   assign stat.id_zero    = id_ff == 32'd0;
   assign stat.id_is_last = id_ff == last_ff;
   assign stat.overflow   = ovf_ff;
   assign stat.idx_end    = idx_ff >= ws_cnt_ff;
   assign stat.ws_match   = ws_rd == id_ff;
   assign stat.hash_done  = cnt_ff == HASH_LAST;
   assign stat.mod_done   = cnt_ff == MOD_LAST;
   assign stat.clr_done   = clr_ff == SLOT_W'(SLOT_COUNT - 1);
   assign stat.rsp_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_inv_ff;

endmodule

/* rtl/rwst_ctrl.sv */
// ----------------------------------------------------------------------------
// rwst_ctrl
// Sequencer of the write-stamp table: clear pass, action dispatch, write-set
// search, commit walk, slot hash and read-modify-write.
// ----------------------------------------------------------------------------
module rwst_ctrl
   import rwst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (stat.action)
               ACT_WRITE: begin
                  if (!stat.track || stat.id_zero || stat.id_is_last) state_in = ST_DONE;
                  else state_in = ST_SRCH_RD;
               end
               ACT_READ: begin
                  if (!stat.track || stat.id_zero) state_in = ST_DONE;
                  else state_in = ST_HASH;
               end
               ACT_COMMIT: begin
                  state_in = stat.track ? ST_CMT_RD : ST_DONE;
               end
               ACT_QUERY: begin
                  if (stat.id_is_last || stat.overflow) state_in = ST_DONE;
                  else state_in = ST_SRCH_RD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SRCH_RD: begin
            if (!stat.idx_end) state_in = ST_SRCH_CMP;
            else if (stat.action == ACT_WRITE) state_in = ST_HASH;
            else state_in = ST_DONE;
         end
         ST_SRCH_CMP: begin
            state_in = stat.ws_match ? ST_DONE : ST_SRCH_RD;
         end
         ST_CMT_RD: begin
            state_in = stat.idx_end ? ST_DONE : ST_CMT_LOAD;
         end
         ST_CMT_LOAD: begin
            state_in = ST_HASH;
         end
         ST_HASH: begin
            if (stat.hash_done) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (stat.mod_done) state_in = ST_SLOT_RD;
         end
         ST_SLOT_RD: begin
            state_in = ST_SLOT_USE;
         end
         ST_SLOT_USE: begin
            state_in = (stat.action == ACT_COMMIT) ? ST_CMT_RD : ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
         end
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_DISPATCH: begin
            case (stat.action)
               ACT_WRITE: begin
                  cmd.idx_clear = 1'b1;
               end
               ACT_READ: begin
                  if (!stat.track || stat.id_zero) cmd.res_invalid = 1'b1;
                  else cmd.hash_init = 1'b1;
               end
               ACT_INVAL: begin
                  cmd.epoch_inc = stat.track;
               end
               ACT_COMMIT: begin
                  cmd.idx_clear = 1'b1;
               end
               ACT_END: begin
                  cmd.ws_clear = 1'b1;
               end
               ACT_QUERY: begin
                  if (stat.id_is_last || stat.overflow) cmd.res_wrote = 1'b1;
                  else cmd.idx_clear = 1'b1;
               end
               default: begin
                  cmd = '0;
               end
            endcase
         end
         ST_SRCH_RD: begin
            if (stat.idx_end && stat.action == ACT_WRITE) begin
               cmd.ws_append = 1'b1;
               cmd.hash_init = 1'b1;
            end
         end
         ST_SRCH_CMP: begin
            if (stat.ws_match) begin
               cmd.last_set  = stat.action == ACT_WRITE;
               cmd.res_wrote = stat.action == ACT_QUERY;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_CMT_RD: begin
            cmd.epoch_inc = stat.idx_end & stat.overflow;
         end
         ST_CMT_LOAD: begin
            cmd.hash_init    = 1'b1;
            cmd.hash_init_ws = 1'b1;
            cmd.idx_inc      = 1'b1;
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
         end
         ST_SLOT_RD: begin
            cmd = '0;
         end
         ST_SLOT_USE: begin
            if (stat.action == ACT_READ) cmd.res_read = 1'b1;
            else cmd.slot_wr = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/relation_write_stamp_table_top.sv */
// ----------------------------------------------------------------------------
// relation_write_stamp_table_top
// Direct-mapped relation write-stamp table with transaction write set.
//
// Usage: items enter on req_ (action in tuser, relation id in tdata), each
// item gives exactly one result on rsp_. track_writes is to be written on
// csr_ only while no item is in flight; the block does not enforce this.
// After reset the slot table is swept to zero, one slot per cycle, from
// slot 0 to SLOT_COUNT-1; req_tready stays low during the sweep.
// One item is worked at a time. A write-set search reads and compares
// each stored id in turn. Every slot access runs the hash, the reciprocal
// remainder unit and a slot read-modify-write.
// The result waits in an output register; a stalled receiver holds it and
// the next item is accepted meanwhile, finishing when the register frees.
// ----------------------------------------------------------------------------
module relation_write_stamp_table_top
   import rwst_pkg::*;
#(
   parameter int SLOT_COUNT      = 8192,
   parameter int WRITE_SET_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] relation_id
   input  logic [2:0]   req_tuser,   // [2:0] action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata,   // [63:0] stamp_value, [127:64] slot_generation,
                                     // [191:128] epoch_value, [192] wrote_flag
   output logic         rsp_tuser,   // [0] reading_invalid
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data     // track_writes
);

   cmd_type    cmd;
   status_type stat;

   assign csr_ready = 1'b1;

   rwst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rwst_datapath #(
      .SLOT_COUNT      (SLOT_COUNT),
      .WRITE_SET_DEPTH (WRITE_SET_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/rwst_checker.sv */
// ----------------------------------------------------------------------------
// rwst_checker
// Port-level checks of the write-stamp table.
// ----------------------------------------------------------------------------
module rwst_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         csr_valid,
   input logic         csr_ready
);

   a_rst_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("busy right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 200'd0)
      else $error("invalid reading carries data");

   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted back to back");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> req_tready && !rsp_tvalid)
      else $error("register written with an item in flight");

endmodule

bind relation_write_stamp_table_top rwst_checker u_rwst_checker (.*);
